### hw/rtl/adsr4_pkg.sv
// Package for the four-channel ADSR envelope core.
// Holds the beat payload types, the per-channel state record and the operation codes.
// No dependencies.
package adsr4_pkg;

  // Operation codes carried in the func field
  localparam logic [2:0] FUNC_TICK        = 3'd0;
  localparam logic [2:0] FUNC_KEY_ON      = 3'd1;
  localparam logic [2:0] FUNC_KEY_OFF     = 3'd2;
  localparam logic [2:0] FUNC_LOAD        = 3'd3;
  localparam logic [2:0] FUNC_RELEASE_ALL = 3'd4;

  // Gate event codes
  localparam logic [1:0] GATE_NONE    = 2'd0;
  localparam logic [1:0] GATE_ON      = 2'd1;
  localparam logic [1:0] GATE_OFF     = 2'd2;
  localparam logic [1:0] GATE_ALL_OFF = 2'd3;

  localparam logic [3:0] LEVEL_MAX = 4'd15;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] channel;
    logic [3:0] peak_level;
    logic [2:0] attack_code;
    logic [2:0] decay_code;
    logic [3:0] sustain_value;
    logic [2:0] release_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_channel;
    logic [3:0] level;
    logic       changed;
    logic [1:0] gate_event;
    logic       last;
  } out_item_t;

  // One memory word per channel; speeds and divisors pack attack in 2:0,
  // decay in 5:3 and release in 8:6
  typedef struct packed {
    logic       key_held;
    logic       peak_reached;
    logic [2:0] tick_count;
    logic [3:0] cur_level;
    logic [3:0] target_peak;
    logic [3:0] sustain_target;
    logic [8:0] stage_speeds;
    logic [8:0] stage_divisors;
  } chan_state_t;

  // What the update logic reports for one channel
  typedef struct packed {
    logic [3:0] level;
    logic       changed;
    logic [1:0] gate_event;
  } chan_report_t;

endpackage

### hw/rtl/adsr_envelope_four_channel_core.sv
// Four-channel ADSR envelope core. Per-channel state sits in one memory, read ahead through a registered read port.
// Tick and release-all do one memory read-modify-write per channel; key on, key off and load
// update one channel; ignored beats are dropped. A new beat is taken only once the last result
// of the previous one has been loaded into the output register.
// Reset (synchronous): clears the FSM, output valid and every entry's valid bit; an
// entry that is not valid reads as all zero, so no clearing pass is needed.
module adsr_envelope_four_channel_core #(
  parameter int CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  adsr4_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output adsr4_pkg::out_item_t result
);
  import adsr4_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

  typedef enum logic {S_IDLE, S_CALC} state_t;

  state_t      state;
  logic [IW-1:0] idx;
  logic        multi;
  in_item_t    op_item;

  // Channel state memory and its valid bits
  chan_state_t mem [CHANNELS];
  logic [CHANNELS-1:0] valid_bits;
  chan_state_t rd_q;
  logic        rd_hit;
  logic        rd_en;
  logic [IW-1:0] rd_addr;
  logic        wr_en;

  chan_state_t  entry;
  chan_state_t  upd_state;
  chan_report_t upd_rep;

  logic        is_multi;
  logic        is_single;
  logic [IW+1:0] ch_ext;
  logic [IW+1:0] idx_ext;
  logic        commit;
  logic        last_ch;

  assign is_multi  = (item.func == FUNC_TICK) || (item.func == FUNC_RELEASE_ALL);
  assign is_single = ((item.func == FUNC_KEY_ON) || (item.func == FUNC_KEY_OFF) ||
                      (item.func == FUNC_LOAD)) && (32'(item.channel) < CHANNELS);
  assign ch_ext    = (IW + 2)'(item.channel);
  assign idx_ext   = {2'b00, idx};

  assign item_ready = (state == S_IDLE);
  assign commit     = (state == S_CALC) && (!result_valid || result_ready);
  assign last_ch    = !multi || (idx == LAST_IDX);
  assign wr_en      = commit;

  // Issue reads: first channel on acceptance, next channel on each commit but the last
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx + IW'(1);
    if (state == S_IDLE && item_valid) begin
      rd_en   = is_multi || is_single;
      rd_addr = is_multi ? '0 : ch_ext[IW-1:0];
    end else if (commit && !last_ch) begin
      rd_en = 1'b1;
    end
  end

  // Hold state words; read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= upd_state;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Track which entries were written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_hit     <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_bits[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid_bits[rd_addr];
      end
    end
  end

  assign entry = rd_hit ? rd_q : '0;

  adsr4_chan_update u_update (
    .op   (op_item.func),
    .item (op_item),
    .cur  (entry),
    .nxt  (upd_state),
    .rep  (upd_rep)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      multi        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Load a result beat on each commit; drop it once taken
      if (commit) begin
        result_valid       <= 1'b1;
        result.out_channel <= idx_ext[1:0];
        result.level       <= upd_rep.level;
        result.changed     <= upd_rep.changed;
        result.gate_event  <= upd_rep.gate_event;
        result.last        <= last_ch;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op_item <= item;
            multi   <= is_multi;
            idx     <= is_multi ? '0 : ch_ext[IW-1:0];
            if (is_multi || is_single) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (commit) begin
            if (last_ch) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/adsr4_chan_update.sv
// Per-channel envelope update: applies one operation to one channel's state word.
// Depends on adsr4_pkg for the state record, payload and operation codes.
module adsr4_chan_update (
  input  logic [2:0]            op,
  input  adsr4_pkg::in_item_t    item,
  input  adsr4_pkg::chan_state_t cur,
  output adsr4_pkg::chan_state_t nxt,
  output adsr4_pkg::chan_report_t rep
);
  import adsr4_pkg::*;

  logic [4:0] a;
  logic [2:0] tc;
  logic       pr;
  logic [3:0] sus_sel;

  // Step size for a stage code: 1,2,3 give 4,3,2; 4..7 give 1; 0 is instant
  function automatic logic [2:0] code_speed(input logic [2:0] code);
    logic [2:0] r;
    if (code == 3'd0) begin
      r = 3'd0;
    end else if (code < 3'd4) begin
      r = 3'd5 - code;
    end else begin
      r = 3'd1;
    end
    return r;
  endfunction

  // Tick divisor for a stage code: 1..4 give 1; 5,6,7 give 2,3,4; 0 is instant
  function automatic logic [2:0] code_divisor(input logic [2:0] code);
    logic [2:0] r;
    if (code == 3'd0) begin
      r = 3'd0;
    end else if (code > 3'd4) begin
      r = code - 3'd3;
    end else begin
      r = 3'd1;
    end
    return r;
  endfunction

  assign sus_sel = (item.sustain_value == 4'd0 && item.decay_code == 3'd0) ?
                   item.peak_level : item.sustain_value;

  always_comb begin
    nxt            = cur;
    a              = {1'b0, cur.cur_level};
    tc             = cur.tick_count;
    pr             = cur.peak_reached;
    rep.changed    = 1'b0;
    rep.gate_event = GATE_NONE;
    unique case (op)
      FUNC_TICK: begin
        if (cur.key_held) begin
          // Attack: ramp toward the peak
          if (!pr) begin
            if (cur.stage_divisors[2:0] == 3'd0) begin
              pr = 1'b1;
              a  = {1'b0, cur.target_peak};
            end else begin
              tc = tc + 3'd1;
              if (tc >= cur.stage_divisors[2:0]) begin
                a = a + {2'b00, cur.stage_speeds[2:0]};
                if (a >= {1'b0, cur.target_peak}) begin
                  a  = {1'b0, cur.target_peak};
                  pr = 1'b1;
                end
                tc = 3'd0;
              end
            end
          end
          // Decay: step down to sustain, then hold
          if (pr) begin
            if (cur.stage_divisors[5:3] == 3'd0) begin
              a = {1'b0, cur.sustain_target};
            end else if (a > {1'b0, cur.sustain_target}) begin
              tc = tc + 3'd1;
              if (tc >= cur.stage_divisors[5:3]) begin
                a = (a < {2'b00, cur.stage_speeds[5:3]}) ? 5'd0 :
                    a - {2'b00, cur.stage_speeds[5:3]};
                if (a < {1'b0, cur.sustain_target}) begin
                  a = {1'b0, cur.sustain_target};
                end
                tc = 3'd0;
              end
            end
          end
        end else if (a != 5'd0) begin
          // Release: step down to zero
          if (cur.stage_divisors[8:6] == 3'd0) begin
            a = 5'd0;
          end else begin
            tc = tc + 3'd1;
            if (tc >= cur.stage_divisors[8:6]) begin
              a = (a < {2'b00, cur.stage_speeds[8:6]}) ? 5'd0 :
                  a - {2'b00, cur.stage_speeds[8:6]};
              tc = 3'd0;
            end
          end
        end
        a = a & {1'b0, LEVEL_MAX};
        // Flag level movement and gate edges
        if (a[3:0] != cur.cur_level) begin
          rep.changed   = 1'b1;
          nxt.cur_level = a[3:0];
          if (cur.cur_level == 4'd0) begin
            tc             = 3'd0;
            rep.gate_event = GATE_ON;
          end else if (a[3:0] == 4'd0) begin
            tc             = 3'd0;
            rep.gate_event = GATE_OFF;
          end
        end
        nxt.tick_count   = tc;
        nxt.peak_reached = pr;
      end
      FUNC_KEY_ON: begin
        nxt.key_held     = 1'b1;
        nxt.peak_reached = 1'b0;
        nxt.tick_count   = 3'd0;
      end
      FUNC_KEY_OFF, FUNC_RELEASE_ALL: begin
        nxt.key_held = 1'b0;
      end
      FUNC_LOAD: begin
        nxt.target_peak    = item.peak_level;
        nxt.sustain_target = sus_sel;
        nxt.stage_speeds   = {code_speed(item.release_code), code_speed(item.decay_code),
                              code_speed(item.attack_code)};
        nxt.stage_divisors = {code_divisor(item.release_code),
                              code_divisor(item.decay_code),
                              code_divisor(item.attack_code)};
        nxt.tick_count     = 3'd0;
        nxt.key_held       = 1'b0;
        nxt.cur_level      = 4'd0;
        rep.changed        = (cur.cur_level != 4'd0);
        rep.gate_event     = GATE_ALL_OFF;
      end
      default: begin
        nxt = cur;
      end
    endcase
    rep.level = nxt.cur_level;
  end

endmodule

### hw/rtl/adsr4_checker.sv
// Port-level checks for the ADSR envelope core, bound to the top level.
// Depends on adsr4_pkg for payload types and codes.
module adsr4_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input adsr4_pkg::in_item_t  item,
  input logic                 result_valid,
  input logic                 result_ready,
  input adsr4_pkg::out_item_t result
);
  import adsr4_pkg::*;

  // Hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // No new input while a multi-channel sweep is still reporting
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> !item_ready)
    else $error("input taken during a channel sweep");

  // A key on for a present channel occupies the core for the next cycle
  a_key_on_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.func == FUNC_KEY_ON |=> !item_ready)
    else $error("key on did not start a channel update");

  // Load reports a zero level and always ends its input
  a_load_report: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.gate_event == GATE_ALL_OFF |-> result.level == 4'd0 && result.last)
    else $error("load result malformed");

  // Nothing to report straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind adsr_envelope_four_channel_core adsr4_checker u_adsr4_checker (.*);
